// File: rtl/fde_pkg.sv
// shared types, constants and helpers for the feedback delay echo
`timescale 1ns / 1ps

package fde_pkg;

  localparam int SAMPLE_W = 16;
  localparam int ADDR_W   = 16;
  localparam int DEPTH    = 1 << ADDR_W;
  localparam int DLY_W    = 16;
  localparam int GAIN_W   = 16;
  localparam int WET_W    = 17;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 17;
  localparam int SUM_W    = 20;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [ADDR_W-1:0]          addr_t;
  typedef logic [DLY_W-1:0]           dly_t;
  typedef logic [GAIN_W-1:0]          gain_t;
  typedef logic [WET_W-1:0]           wet_t;
  typedef logic [CFG_IDX_W-1:0]       cfg_idx_t;
  typedef logic signed [SUM_W-1:0]    sum_t;

  localparam cfg_idx_t REG_DELAY_LENGTH  = 2'd0;
  localparam cfg_idx_t REG_FEEDBACK_GAIN = 2'd1;
  localparam cfg_idx_t REG_WET_LEVEL     = 2'd2;

  localparam dly_t  DELAY_RESET = 16'd13230;
  localparam gain_t GAIN_RESET  = 16'd26214;
  localparam wet_t  WET_RESET   = 17'd32768;
  localparam wet_t  WET_ONE     = 17'd65536;

  localparam sum_t    SAT_HI     = 20'sd32767;
  localparam sum_t    SAT_LO     = -20'sd32768;
  localparam sample_t SAMPLE_MAX = 16'sh7fff;
  localparam sample_t SAMPLE_MIN = 16'sh8000;

  function automatic sample_t sat_sample(input sum_t v);
    sample_t r;
    if (v > SAT_HI) begin
      r = SAMPLE_MAX;
    end else if (v < SAT_LO) begin
      r = SAMPLE_MIN;
    end else begin
      r = v[SAMPLE_W-1:0];
    end
    return r;
  endfunction

endpackage

// File: rtl/fde_mix.sv
// feedback and dry/wet mix arithmetic: product stage then round and saturate
`timescale 1ns / 1ps

module fde_mix
  import fde_pkg::*;
(
  input  logic    clk,
  input  logic    en,
  input  sample_t dry_x,
  input  sample_t dly_s,
  input  gain_t   gain,
  input  wet_t    wet,
  output sample_t fb_sample,
  output sample_t mix_sample
);

  wet_t wet_eff;
  wet_t dry_eff;

  sample_t            b_x;
  logic signed [32:0] p_fb;
  logic signed [33:0] p_dry;
  logic signed [33:0] p_wet;

  logic signed [33:0] fb_rnd;
  logic signed [34:0] mix_sum;

  always_comb begin
    wet_eff = (wet > WET_ONE) ? WET_ONE : wet;
    dry_eff = WET_ONE - wet_eff;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_x   <= dry_x;
      p_fb  <= dly_s * $signed({1'b0, gain});
      p_dry <= dry_x * $signed({1'b0, dry_eff});
      p_wet <= dly_s * $signed({1'b0, wet_eff});
    end
  end

  always_comb begin
    fb_rnd  = {p_fb[32], p_fb} + 34'sd32768;
    mix_sum = {p_dry[33], p_dry} + {p_wet[33], p_wet} + 35'sd32768;
    fb_sample  = sat_sample(sum_t'(b_x) + sum_t'($signed(fb_rnd[33:16])));
    mix_sample = sat_sample(sum_t'($signed(mix_sum[34:16])));
  end

endmodule

// File: rtl/feedback_delay_echo.sv
// top level of the feedback delay echo: config registers, delay memory, pipeline control
`timescale 1ns / 1ps

// Echo effect on a 65536-entry circular delay memory. Each sample reads the
// entry the effective delay (delay_length, zero taken as one) behind the
// write pointer and writes back itself plus the scaled delayed sample;
// the output is the rounded, saturated dry/wet mix. One sample per cycle
// is taken when the effective delay is three or more and the output is
// not stalled; for a delay of one or two, input stalls until the earlier
// sample's write-back has landed in the memory (read, multiply, then
// round and write back). No clearing pass is needed after reset: entries
// not yet written since reset read as zero, tracked by the write pointer
// and a wrap flag. Configuration writes are always taken and are meant for
// an idle block.
module feedback_delay_echo
  import fde_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  sample_t   in_sample,
  output logic      out_valid,
  input  logic      out_stall,
  output sample_t   out_sample,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  cfg_idx_t  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  sample_t delay_mem [DEPTH];

  dly_t  dly_len;
  gain_t gain;
  wet_t  wet;

  addr_t wp;
  logic  wrapped;

  logic    a_v;
  sample_t a_x;
  addr_t   a_wp;
  logic    a_hit;
  sample_t q;

  logic  b_v;
  addr_t b_wp;

  addr_t   dly_eff;
  addr_t   rd;
  logic    rd_hit;
  logic    hazard;
  logic    adv;
  logic    accept;
  sample_t s;
  sample_t fb_sample;
  sample_t mix_sample;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      dly_len <= DELAY_RESET;
      gain    <= GAIN_RESET;
      wet     <= WET_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_DELAY_LENGTH:  dly_len <= cfg_data[DLY_W-1:0];
        REG_FEEDBACK_GAIN: gain    <= cfg_data[GAIN_W-1:0];
        REG_WET_LEVEL:     wet     <= cfg_data[WET_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (dly_len == '0) begin
      dly_eff = addr_t'(1);
    end else if (32'(dly_len) >= DEPTH) begin
      dly_eff = addr_t'(DEPTH - 1);
    end else begin
      dly_eff = addr_t'(dly_len);
    end
    rd     = wp - dly_eff;
    rd_hit = wrapped || (rd < wp);
    hazard = (a_v && (a_wp == rd)) || (b_v && (b_wp == rd));
    adv    = !out_valid || !out_stall;
    in_stall = !adv || hazard;
    accept = in_valid && !in_stall;
    s      = a_hit ? q : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp      <= '0;
      wrapped <= 1'b0;
      a_v     <= 1'b0;
      b_v     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        wp <= wp + addr_t'(1);
        if (wp == addr_t'(DEPTH - 1)) begin
          wrapped <= 1'b1;
        end
      end
      if (adv) begin
        a_v       <= accept;
        b_v       <= a_v;
        out_valid <= b_v;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_x   <= in_sample;
      a_wp  <= wp;
      a_hit <= rd_hit;
    end
    if (adv) begin
      b_wp <= a_wp;
      if (b_v) begin
        out_sample <= mix_sample;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      q <= delay_mem[rd];
    end
    if (adv && b_v) begin
      delay_mem[b_wp] <= fb_sample;
    end
  end

  fde_mix u_mix (
    .clk        (clk),
    .en         (adv),
    .dry_x      (a_x),
    .dly_s      (s),
    .gain       (gain),
    .wet        (wet),
    .fb_sample  (fb_sample),
    .mix_sample (mix_sample)
  );

endmodule

// File: tb/sv/tb.sv
// self-checking testbench for the feedback delay echo with a sample-level scoreboard
`timescale 1ns / 1ps

module tb;
  import fde_pkg::*;

  localparam cfg_idx_t REG_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES = 400;

  class echo_scoreboard;
    int      echo_mem[DEPTH];
    int      wr_ptr;
    dly_t    delay_len;
    gain_t   fb_gain;
    wet_t    wet_mix;
    sample_t expected_q[$];
    int      n_inputs;
    int      n_outputs;
    int      n_errors;

    function void reset_state();
      foreach (echo_mem[i]) echo_mem[i] = 0;
      wr_ptr = 0;
      delay_len = DELAY_RESET;
      fb_gain = GAIN_RESET;
      wet_mix = WET_RESET;
      expected_q.delete();
    endfunction

    function longint clip(longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
    endfunction

    // divide by 65536, round half up
    function longint rnd16(longint v);
      return (v + 32768) >>> 16;
    endfunction

    function void set_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_DELAY_LENGTH: delay_len = data[DLY_W-1:0];
        REG_FEEDBACK_GAIN: fb_gain = data[GAIN_W-1:0];
        REG_WET_LEVEL: wet_mix = data[WET_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_input(sample_t x);
      longint d, w, g, xs, s, fb, y;
      int rd;
      d = delay_len;
      if (d < 1) d = 1;
      if (d >= DEPTH) d = DEPTH - 1;
      w = wet_mix;
      if (w > 65536) w = 65536;
      g = fb_gain;
      rd = int'((wr_ptr + DEPTH - d) % DEPTH);
      xs = x;
      s = echo_mem[rd];
      fb = clip(xs + rnd16(s * g));
      echo_mem[wr_ptr] = int'(fb);
      y = clip(rnd16(xs * (65536 - w) + s * w));
      expected_q.push_back(sample_t'(y));
      wr_ptr = (wr_ptr + 1) % DEPTH;
      n_inputs++;
    endfunction

    function void check_output(sample_t y);
      sample_t exp_y;
      n_outputs++;
      if (expected_q.size() == 0) begin
        if (n_errors < 10) $display("unexpected output beat: out_sample %0d", y);
        n_errors++;
      end else begin
        exp_y = expected_q.pop_front();
        if (y !== exp_y) begin
          if (n_errors < 10)
            $display("output beat %0d: out_sample expected %0d, got %0d",
                     n_outputs, exp_y, y);
          n_errors++;
        end
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  sample_t               in_sample = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b1;
  sample_t               out_sample;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  cfg_idx_t              cfg_index = REG_DELAY_LENGTH;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  echo_scoreboard sb = new();
  int send_idle = 11;
  int recv_idle = 52;
  int hold_left = 0;
  int n_settings = 0;

  wire any_beat = (in_valid && !in_stall) || (out_valid && !out_stall) ||
                  (cfg_valid && cfg_ready);

  always #6 clk = ~clk;

  feedback_delay_echo DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_sample(in_sample),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_sample(out_sample),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) sb.set_reg(cfg_index, cfg_data);
      if (in_valid && !in_stall) sb.note_input(in_sample);
      if (out_valid && !out_stall) sb.check_output(out_sample);
    end
  end

  // output side stall, with an optional long hold-off
  initial begin
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle);
      end
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (any_beat) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("feedback_delay_echo: mismatch");
    $finish;
  end

  task automatic send_sample(sample_t x);
    @(negedge clk);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_sample <= x;
    do @(posedge clk); while (!(in_valid && !in_stall));
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic apply_setting(logic [CFG_DATA_W-1:0] dly, logic [CFG_DATA_W-1:0] gain,
                               logic [CFG_DATA_W-1:0] wet);
    cfg_write(REG_DELAY_LENGTH, dly);
    cfg_write(REG_FEEDBACK_GAIN, gain);
    cfg_write(REG_WET_LEVEL, wet);
    n_settings++;
  endtask

  function automatic sample_t pick_sample();
    case ($urandom_range(9))
      0: return SAMPLE_MAX;
      1: return SAMPLE_MIN;
      2: return '0;
      3: return sample_t'(-1);
      4, 5: return sample_t'(int'($urandom_range(511)) - 256);
      default: return sample_t'($urandom);
    endcase
  endfunction

  task automatic random_setting();
    logic [DLY_W-1:0] d;
    logic [GAIN_W-1:0] g;
    logic [WET_W-1:0] w;
    case ($urandom_range(7))
      0: d = '0;
      1: d = 16'd1;
      2: d = 16'd2;
      3: d = 16'd3;
      4: d = 16'hffff;
      5: d = 16'($urandom_range(40, 4));
      6: d = 16'($urandom_range(2000, 41));
      default: d = 16'($urandom);
    endcase
    case ($urandom_range(3))
      0: g = '0;
      1: g = 16'hffff;
      default: g = 16'($urandom);
    endcase
    case ($urandom_range(4))
      0: w = '0;
      1: w = WET_ONE;
      2: w = 17'($urandom_range(131071, 65537));
      default: w = 17'($urandom_range(65535));
    endcase
    // upper bit of delay and gain data must be dropped
    apply_setting({1'($urandom), d}, {1'($urandom), g}, w);
    if ($urandom_range(3) == 0) cfg_write(REG_UNUSED, 17'($urandom));
  endtask

  task automatic random_phase(int target, bit with_hold);
    int sent;
    int n;
    sent = 0;
    while (sent < target) begin
      if (with_hold && sent == 0) begin
        apply_setting(17'd8, 17'($urandom_range(65535)), 17'($urandom_range(65536)));
        hold_left = HOLD_CYCLES;
        n = 120;
      end else begin
        random_setting();
        n = $urandom_range(120, 30);
      end
      repeat (n) send_sample(pick_sample());
      drain();
      sent += n;
    end
  endtask

  initial begin
    sb.reset_state();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset settings, plain extremes
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    send_sample('0);
    send_sample(sample_t'(-1));
    send_sample(sample_t'(1));
    send_sample(16'sh4000);
    send_sample(16'shc000);
    drain();

    // zero delay acts as one, full gain drives feedback into saturation, fully wet
    apply_setting(17'h10000, 17'h1ffff, WET_ONE);
    repeat (6) send_sample(SAMPLE_MAX);
    repeat (4) send_sample(SAMPLE_MIN);
    drain();

    // longest delay, no feedback, fully dry, write to unused index ignored
    apply_setting(17'hffff, 17'h0, 17'h0);
    cfg_write(REG_UNUSED, 17'h1ffff);
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    send_sample(16'sh1234);
    drain();

    // wet above unity clamps
    apply_setting(17'd2, 17'd32768, 17'h1ffff);
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    send_sample(SAMPLE_MAX);
    send_sample(sample_t'(-1));
    drain();

    random_phase(650, 1'b0);
    send_idle = 52;
    recv_idle = 11;
    random_phase(650, 1'b0);
    send_idle = 0;
    recv_idle = 0;
    random_phase(650, 1'b1);

    repeat (20) @(posedge clk);
    $display("covered %0d samples in, %0d out, over %0d register settings",
             sb.n_inputs, sb.n_outputs, n_settings);
    $display("three idle patterns plus one long output hold-off; %0d mismatches",
             sb.n_errors);
    if (sb.n_errors == 0 && sb.pending() == 0) begin
      $display("feedback_delay_echo: match");
    end else begin
      $display("feedback_delay_echo: mismatch");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/fde_pkg.sv
rtl/fde_mix.sv
rtl/feedback_delay_echo.sv
tb/sv/tb.sv
